@@ rtl/ttce_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the text terminal cursor engine.
package ttce_pkg;

    // operation codes on the input tuser
    localparam logic [1:0] OP_PUT    = 2'd0;
    localparam logic [1:0] OP_SETPOS = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    // control bytes and printable range
    localparam logic [7:0] CH_BS      = 8'h08;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] PRINT_LOW  = 8'h20;
    localparam logic [7:0] PRINT_HIGH = 8'h7F;

    // configuration register indexes
    localparam logic [7:0] REG_BLANK_CHAR = 8'd0;
    localparam logic [7:0] REG_BLANK_FG   = 8'd1;
    localparam logic [7:0] REG_BLANK_BG   = 8'd2;

    // blank cell after reset
    localparam logic [7:0] RST_BLANK_CHAR = 8'd32;
    localparam logic [3:0] RST_BLANK_FG   = 4'd7;
    localparam logic [3:0] RST_BLANK_BG   = 4'd0;

    localparam int CELL_W = 16;

    typedef enum logic [3:0] {
        K_NOP,
        K_PRINT,
        K_BS,
        K_TAB,
        K_CR,
        K_LF,
        K_SETPOS,
        K_CLEAR,
        K_READ
    } t_kind;

    // classified command, col/row already saturated or range checked
    typedef struct packed {
        t_kind      kind;
        logic [7:0] ch;
        logic [3:0] fg;
        logic [3:0] bg;
        logic [7:0] col;
        logic [7:0] row;
    } t_cmd;

    typedef struct packed {
        logic [3:0] cell_bg;
        logic [3:0] cell_fg;
        logic [7:0] cell_char;
        logic [4:0] cursor_row;
        logic [6:0] cursor_col;
    } t_result;

endpackage

@@ rtl/text_terminal_cursor_engine_unit.sv @@
`timescale 1ns / 1ps
// Top level of the character-cell text terminal cursor engine.
//
// Commands arrive on the s_axis channel: tuser carries the operation (put
// character, set position, clear, read cell), tdata the byte, colors and
// target column/row. Each accepted beat yields exactly one m_axis beat with
// the cursor after the step and, for a read, the cell contents.
// Blank cell attributes are set through the cfg write channel (index 0 char,
// 1 foreground, 2 background); write them only while the engine is idle.
// A two-entry command queue sits between the classifier and the executor.
// Path: a beat is registered in the queue, then executed into the m_axis output
// register; a read cell also passes through the RAM read register and ST_READ.
// Throughput: one command per cycle for put, set position and out-of-range reads
// while m_axis is ready; an in-range read waits for its RAM data, and a scroll
// (one row) or clear (whole store) is blanked before the next command executes.
// After reset the whole store is blanked (COLUMNS*ROWS cells, 2000 by default)
// while s_axis tready stays low. A stalled m_axis holds its beat; the queue
// keeps accepting until both entries are full.
module text_terminal_cursor_engine_unit
    import ttce_pkg::*;
#(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int TAB_WIDTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [1:0]  i_s_axis_tuser,   // operation
    input  logic [31:0] i_s_axis_tdata,   // char_code, fore_color, back_color,
                                          // target_col, target_row
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // cursor_col, cursor_row, cell_char,
                                          // cell_fg, cell_bg, zero pad
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    logic [7:0] r_blank_char;
    logic [3:0] r_blank_fg;
    logic [3:0] r_blank_bg;
    logic       cfg_wr;

    logic       cmd_valid;
    t_cmd       cmd;
    logic       cmd_pop;
    logic       init_done;
    t_result    res;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blank_char <= RST_BLANK_CHAR;
            r_blank_fg   <= RST_BLANK_FG;
            r_blank_bg   <= RST_BLANK_BG;
        end else if (cfg_wr) begin
            if (i_cfg_index == REG_BLANK_CHAR) begin
                r_blank_char <= i_cfg_data;
            end else if (i_cfg_index == REG_BLANK_FG) begin
                r_blank_fg <= i_cfg_data[3:0];
            end else if (i_cfg_index == REG_BLANK_BG) begin
                r_blank_bg <= i_cfg_data[3:0];
            end
        end
    end

    ttce_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_init_done (init_done),
        .i_tvalid    (i_s_axis_tvalid),
        .o_tready    (o_s_axis_tready),
        .i_tuser     (i_s_axis_tuser),
        .i_tdata     (i_s_axis_tdata),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    ttce_back #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .TAB_WIDTH (TAB_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_blank     ({r_blank_bg, r_blank_fg, r_blank_char}),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_init_done (init_done),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out       (res)
    );

    assign o_m_axis_tdata = {4'b0000, res};

endmodule

@@ rtl/ttce_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module ttce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/ttce_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts input beats, classifies them and queues commands.
module ttce_front
    import ttce_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_init_done,
    input  logic        i_tvalid,
    output logic        o_tready,
    input  logic [1:0]  i_tuser,
    input  logic [31:0] i_tdata,
    output logic        o_cmd_valid,
    output t_cmd        o_cmd,
    input  logic        i_cmd_pop
);

    localparam logic [7:0] COL_MAX = 8'(COLUMNS - 1);
    localparam logic [7:0] ROW_MAX = 8'(ROWS - 1);

    t_cmd       cls;
    logic [7:0] in_ch;
    logic [7:0] in_col;
    logic [7:0] in_row;
    logic       push;

    t_cmd       r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;

    assign in_ch  = i_tdata[7:0];
    assign in_col = i_tdata[23:16];
    assign in_row = i_tdata[31:24];

    always_comb begin
        cls      = '0;
        cls.kind = K_NOP;
        cls.ch   = in_ch;
        cls.fg   = i_tdata[11:8];
        cls.bg   = i_tdata[15:12];
        cls.col  = in_col;
        cls.row  = in_row;
        case (i_tuser)
            OP_PUT: begin
                if (in_ch == CH_BS) begin
                    cls.kind = K_BS;
                end else if (in_ch == CH_TAB) begin
                    cls.kind = K_TAB;
                end else if (in_ch == CH_CR) begin
                    cls.kind = K_CR;
                end else if (in_ch == CH_LF) begin
                    cls.kind = K_LF;
                end else if (in_ch >= PRINT_LOW && in_ch <= PRINT_HIGH) begin
                    cls.kind = K_PRINT;
                end
            end
            OP_SETPOS: begin
                cls.kind = K_SETPOS;
                cls.col  = (in_col > COL_MAX) ? COL_MAX : in_col;
                cls.row  = (in_row > ROW_MAX) ? ROW_MAX : in_row;
            end
            OP_CLEAR: begin
                cls.kind = K_CLEAR;
            end
            OP_READ: begin
                // out-of-range read returns zeros and leaves the cursor alone
                if (in_col <= COL_MAX && in_row <= ROW_MAX) begin
                    cls.kind = K_READ;
                end
            end
            default: begin
                cls.kind = K_NOP;
            end
        endcase
    end

    assign o_tready    = (r_cnt != 2'd2) && i_init_done;
    assign push        = i_tvalid && o_tready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd_ptr];

    always_comb begin
        n_cnt = r_cnt;
        if (push && !i_cmd_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!push && i_cmd_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_cmd_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cls;
        end
    end

endmodule

@@ rtl/ttce_back.sv @@
`timescale 1ns / 1ps
// Back end: cursor state, screen store with row rotation, blanking sweeps.
module ttce_back
    import ttce_pkg::*;
#(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int TAB_WIDTH = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [CELL_W-1:0] i_blank,
    input  logic              i_cmd_valid,
    input  t_cmd              i_cmd,
    output logic              o_cmd_pop,
    output logic              o_init_done,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_result           o_out
);

    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);

    localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);
    localparam logic [RW:0]   ROWS_EXT  = (RW + 1)'(ROWS);
    localparam logic [AW-1:0] COLS_A    = AW'(COLUMNS);
    localparam logic [AW-1:0] CELL_LAST = AW'(CELLS - 1);
    localparam logic [CELL_W-1:0] RST_BLANK = {RST_BLANK_BG, RST_BLANK_FG, RST_BLANK_CHAR};

    typedef enum logic [2:0] {
        ST_RUN   = 3'b001,
        ST_READ  = 3'b010,
        ST_SWEEP = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0]     r_col, n_col;
    logic [RW-1:0]     r_row, n_row;
    logic [RW-1:0]     r_top, n_top;
    logic [AW-1:0]     r_sweep_addr, n_sweep_addr;
    logic [AW-1:0]     r_sweep_end, n_sweep_end;
    logic [CELL_W-1:0] r_sweep_cell, n_sweep_cell;
    logic              r_init_done, n_init_done;
    logic              r_out_valid, n_out_valid;
    t_result           r_out, n_out;

    // tab stop per column, with a flag when it runs past the last column
    logic [CW-1:0] tab_col [COLUMNS];
    logic          tab_wrap [COLUMNS];

    for (genvar gi = 0; gi < COLUMNS; gi++) begin : g_tab
        localparam int NEXT = ((gi / TAB_WIDTH) + 1) * TAB_WIDTH;
        assign tab_wrap[gi] = (NEXT >= COLUMNS);
        assign tab_col[gi]  = (NEXT >= COLUMNS) ? '0 : CW'(NEXT);
    end

    // logical row/col to store address, rotated by the top-row offset
    logic [RW-1:0]     a_row;
    logic [CW-1:0]     a_col;
    logic [RW:0]       row_sum;
    logic [RW-1:0]     phys_row;
    logic [AW-1:0]     cmd_addr;
    logic [AW-1:0]     top_base;
    logic              is_read;

    assign is_read  = (i_cmd.kind == K_READ);
    assign a_row    = is_read ? i_cmd.row[RW-1:0] : r_row;
    assign a_col    = is_read ? i_cmd.col[CW-1:0] :
                      (i_cmd.kind == K_BS) ? (r_col - CW'(1)) : r_col;
    assign row_sum  = {1'b0, a_row} + {1'b0, r_top};
    assign phys_row = (row_sum >= ROWS_EXT) ? RW'(row_sum - ROWS_EXT) : RW'(row_sum);
    assign cmd_addr = AW'(phys_row) * COLS_A + AW'(a_col);
    assign top_base = AW'(r_top) * COLS_A;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic              ram_re;
    logic [CELL_W-1:0] ram_rdata;
    logic              adv_row;
    logic              go;

    ttce_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (cmd_addr),
        .o_rdata (ram_rdata)
    );

    assign go = (r_state == ST_RUN) && i_cmd_valid && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state      = r_state;
        n_col        = r_col;
        n_row        = r_row;
        n_top        = r_top;
        n_sweep_addr = r_sweep_addr;
        n_sweep_end  = r_sweep_end;
        n_sweep_cell = r_sweep_cell;
        n_init_done  = r_init_done;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out        = r_out;
        ram_we       = 1'b0;
        ram_waddr    = cmd_addr;
        ram_wdata    = {i_cmd.bg, i_cmd.fg, i_cmd.ch};
        ram_re       = 1'b0;
        adv_row      = 1'b0;
        o_cmd_pop    = 1'b0;
        case (r_state)
            ST_RUN: begin
                if (go) begin
                    o_cmd_pop   = 1'b1;
                    n_out_valid = 1'b1;
                    case (i_cmd.kind)
                        K_PRINT: begin
                            ram_we = 1'b1;
                            if (r_col == COL_LAST) begin
                                n_col   = '0;
                                adv_row = 1'b1;
                            end else begin
                                n_col = r_col + CW'(1);
                            end
                        end
                        K_BS: begin
                            if (r_col != '0) begin
                                ram_we    = 1'b1;
                                ram_wdata = i_blank;
                                n_col     = r_col - CW'(1);
                            end
                        end
                        K_TAB: begin
                            n_col   = tab_col[r_col];
                            adv_row = tab_wrap[r_col];
                        end
                        K_CR: begin
                            n_col = '0;
                        end
                        K_LF: begin
                            n_col   = '0;
                            adv_row = 1'b1;
                        end
                        K_SETPOS: begin
                            n_col = i_cmd.col[CW-1:0];
                            n_row = i_cmd.row[RW-1:0];
                        end
                        K_CLEAR: begin
                            n_col        = '0;
                            n_row        = '0;
                            n_top        = '0;
                            n_sweep_addr = '0;
                            n_sweep_end  = CELL_LAST;
                            n_sweep_cell = i_blank;
                            n_state      = ST_SWEEP;
                        end
                        K_READ: begin
                            ram_re      = 1'b1;
                            n_out_valid = 1'b0;
                            n_state     = ST_READ;
                        end
                        default: begin
                        end
                    endcase
                    if (adv_row) begin
                        if (r_row == ROW_LAST) begin
                            // scroll: old top row becomes the blanked bottom row
                            n_top        = (r_top == ROW_LAST) ? '0 : r_top + RW'(1);
                            n_sweep_addr = top_base;
                            n_sweep_end  = top_base + AW'(COLUMNS - 1);
                            n_sweep_cell = i_blank;
                            n_state      = ST_SWEEP;
                        end else begin
                            n_row = r_row + RW'(1);
                        end
                    end
                    n_out.cursor_col = 7'(n_col);
                    n_out.cursor_row = 5'(n_row);
                    n_out.cell_char  = '0;
                    n_out.cell_fg    = '0;
                    n_out.cell_bg    = '0;
                end
            end
            ST_READ: begin
                n_out_valid      = 1'b1;
                n_out.cursor_col = 7'(r_col);
                n_out.cursor_row = 5'(r_row);
                n_out.cell_char  = ram_rdata[7:0];
                n_out.cell_fg    = ram_rdata[11:8];
                n_out.cell_bg    = ram_rdata[15:12];
                n_state          = ST_RUN;
            end
            ST_SWEEP: begin
                ram_we    = 1'b1;
                ram_waddr = r_sweep_addr;
                ram_wdata = r_sweep_cell;
                if (r_sweep_addr == r_sweep_end) begin
                    n_init_done = 1'b1;
                    n_state     = ST_RUN;
                end else begin
                    n_sweep_addr = r_sweep_addr + AW'(1);
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_SWEEP;
            r_col        <= '0;
            r_row        <= '0;
            r_top        <= '0;
            r_sweep_addr <= '0;
            r_sweep_end  <= CELL_LAST;
            r_sweep_cell <= RST_BLANK;
            r_init_done  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_col        <= n_col;
            r_row        <= n_row;
            r_top        <= n_top;
            r_sweep_addr <= n_sweep_addr;
            r_sweep_end  <= n_sweep_end;
            r_sweep_cell <= n_sweep_cell;
            r_init_done  <= n_init_done;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_init_done = r_init_done;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_pop_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> (r_state == ST_RUN))
        else $error("command popped outside run state");

    a_read_follows_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> $past(ram_re))
        else $error("read data state without a read issue");

    a_read_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> !r_out_valid)
        else $error("output slot busy when read data returns");

    a_cursor_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col <= COL_LAST) && (r_row <= ROW_LAST) && (r_top <= ROW_LAST))
        else $error("cursor or top row out of range");

    a_sweep_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SWEEP) |-> (r_sweep_addr <= r_sweep_end))
        else $error("blanking sweep ran past its end");

endmodule
